[hdl/sou_pkg.sv]
// Shared types and constants of the sysex OSC unpacker.
`default_nettype none
package sou_pkg;

  localparam int unsigned MAX_MESSAGE_DEF = 2048;
  localparam int unsigned MAX_TYPES_DEF   = 32;
  localparam int unsigned RAW_LEN_W       = 12;
  localparam int unsigned OUT_TDATA_W     = 24;

  localparam logic [7:0] START_BYTE = 8'hf0;
  localparam logic [7:0] END_BYTE   = 8'hf7;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  localparam logic [7:0] CH_I  = 8'h69;
  localparam logic [7:0] CH_F  = 8'h66;
  localparam logic [7:0] CH_M  = 8'h6d;
  localparam logic [7:0] CH_H  = 8'h68;
  localparam logic [7:0] CH_D  = 8'h64;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] CH_SU = 8'h53;
  localparam logic [7:0] CH_B  = 8'h62;

  localparam logic [16:0] DIV3_RECIP = 17'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_start;
    logic       is_end;
    logic       is_nul;
  } sou_item_t;

endpackage
`default_nettype wire

[hdl/sou_ram.sv]
// Generic single-port-write RAM with a registered read port.
`default_nettype none
module sou_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/sou_front.sv]
// Front end: accepts event bytes, classifies them and queues them for the back end.
`default_nettype none
module sou_front
  import sou_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // in_byte
  input  wire logic s_axis_tlast,
  output logic      head_valid_o,
  output sou_item_t head_o,
  input  wire logic pop_i
);

  sou_item_t   q_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  sou_item_t   item;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_valid_o  = (cnt_q != 2'd0);
  assign head_o        = q_q[rd_q];

  always_comb begin
    item.data     = s_axis_tdata;
    item.last     = s_axis_tlast;
    item.is_start = (s_axis_tdata == START_BYTE);
    item.is_end   = (s_axis_tdata == END_BYTE);
    item.is_nul   = (s_axis_tdata == NUL_BYTE);
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= item;
    end
  end

endmodule
`default_nettype wire

[hdl/sou_back.sv]
// Back end: framing state machine, type walk, 7-bit group unpacking and output register.
`default_nettype none
module sou_back
  import sou_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE = MAX_MESSAGE_DEF,
  parameter int unsigned MAX_TYPES   = MAX_TYPES_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      head_valid_i,
  input  sou_item_t      head_i,
  output logic           pop_o,
  output logic           m_axis_tvalid,
  input  wire logic      m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_byte, raw_length, zero pad
  output logic           m_axis_tlast,          // end_mark
  output logic           m_axis_tuser           // bad_frame
);

  localparam int unsigned PEND_MAX = (8 * MAX_TYPES > MAX_MESSAGE + 4) ?
                                     8 * MAX_TYPES : MAX_MESSAGE + 4;
  localparam int unsigned PW  = $clog2(PEND_MAX + 1);
  localparam int unsigned BW  = PW + 1;
  localparam int unsigned CW  = $clog2(MAX_MESSAGE + 1);
  localparam int unsigned TCW = $clog2(MAX_TYPES + 1);
  localparam int unsigned TIW = $clog2(MAX_TYPES);

  typedef enum logic [3:0] {
    S_IDLE, S_PATH, S_TYPES, S_STRING, S_GROUP, S_DONE, S_DRAIN,
    S_WALK_RD, S_WALK_EV, S_BLOB_Q, S_BLOB_P
  } state_e;

  state_e         state_q, state_d;
  logic [TCW-1:0] tcount_q, tcount_d, tptr_q, tptr_d;
  logic [PW-1:0]  pend_q, pend_d, total_q, total_d;
  logic [BW-1:0]  budget_q, budget_d, acc_q, acc_d;
  logic [1:0]     mod_q, mod_d, seen_q, seen_d;
  logic [7:0]     hdr_q, hdr_d, hold_q, hold_d;
  logic [2:0]     gpos_q, gpos_d;
  logic [31:0]    bsize_q, bsize_d;
  logic           nul_q, nul_d, bhead_q, bhead_d, error_q, error_d;
  logic [CW-1:0]  prod_q, prod_d;
  logic [15:0]    quot_q, quot_d;
  logic           ovalid_q, ovalid_d, olast_q, olast_d, obad_q, obad_d;
  logic [7:0]     obyte_q, obyte_d;
  logic [RAW_LEN_W-1:0] olen_q, olen_d;

  logic           we;
  logic [7:0]     rdata;
  logic           slot_free, item_go, phase_state, good;
  logic [BW-1:0]  a1, a2;
  logic [1:0]     m1, m2;
  logic [2:0]     gn, hn;
  logic [7:0]     v;
  logic [31:0]    bs_new;
  logic [32:0]    total_w;
  logic [15:0]    k16, rem16;
  logic [31:0]    prod_mul;
  logic [19:0]    packed_w;
  logic [BW-1:0]  packed_v;
  logic           fin_go;
  logic [7:0]     fin_v;
  logic [BW-1:0]  fin_budget;
  logic [PW-1:0]  fin_pend;
  logic           tflag;
  logic [CW+RAW_LEN_W-1:0] prod_ext;

  sou_ram #(.WIDTH(8), .DEPTH(MAX_TYPES)) u_types (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tcount_q[TIW-1:0]),
    .wdata_i (head_i.data),
    .raddr_i (tptr_q[TIW-1:0]),
    .rdata_o (rdata)
  );

  assign slot_free   = !ovalid_q || m_axis_tready;
  assign phase_state = (state_q == S_IDLE) || (state_q == S_PATH) || (state_q == S_TYPES) ||
                       (state_q == S_STRING) || (state_q == S_GROUP) ||
                       (state_q == S_DONE) || (state_q == S_DRAIN);
  assign item_go     = head_valid_i && slot_free && phase_state;
  assign pop_o       = item_go;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - RAW_LEN_W - 8){1'b0}}, olen_q, obyte_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = obad_q;

  always_comb begin
    a1 = (mod_q == 2'd2) ? acc_q + BW'(4) : acc_q + BW'(5);
    m1 = (mod_q == 2'd2) ? 2'd0 : mod_q + 2'd1;
    a2 = (m1 == 2'd2) ? a1 + BW'(4) : a1 + BW'(5);
    m2 = (m1 == 2'd2) ? 2'd0 : m1 + 2'd1;
    gn = hdr_q[6] ? 3'd6 : 3'd4;
    hn = head_i.data[6] ? 3'd6 : 3'd4;
    v  = head_i.data | {hdr_q[gpos_q - 3'd1], 7'b0};
    bs_new   = {bsize_q[23:0], v};
    total_w  = 33'd4 + ((33'(bs_new) + 33'd3) & ~33'd3);
    k16      = 16'(total_q >> 2);
    prod_mul = 32'(k16) * 32'(DIV3_RECIP);
    rem16    = k16 - 16'(3 * quot_q);
    packed_w = 20'(14 * 20'(quot_q)) + 20'(5 * 20'(rem16));
    packed_v = BW'(packed_w);
    tflag    = (state_q == S_TYPES) && !nul_q && !head_i.is_nul;
    good     = (state_q == S_DONE) && head_i.is_end && !error_q;
    prod_ext = (CW + RAW_LEN_W)'(prod_q);
  end

  always_comb begin
    state_d = state_q;  tcount_d = tcount_q; tptr_d = tptr_q;
    pend_d = pend_q;    total_d = total_q;   budget_d = budget_q;
    acc_d = acc_q;      mod_d = mod_q;       seen_d = seen_q;
    hdr_d = hdr_q;      hold_d = hold_q;     gpos_d = gpos_q;
    bsize_d = bsize_q;  nul_d = nul_q;       bhead_d = bhead_q;
    error_d = error_q;  prod_d = prod_q;     quot_d = quot_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    obyte_d = obyte_q;  olast_d = olast_q;   obad_d = obad_q;  olen_d = olen_q;
    we = 1'b0;
    fin_go = 1'b0; fin_v = v; fin_budget = budget_q; fin_pend = pend_q;

    if (item_go && head_i.last) begin
      ovalid_d = 1'b1;
      obyte_d  = 8'd0;
      olast_d  = 1'b1;
      obad_d   = !good;
      olen_d   = good ? prod_ext[RAW_LEN_W-1:0] : '0;
      state_d  = S_IDLE;
      tcount_d = '0; tptr_d = '0; pend_d = '0; budget_d = '0; hdr_d = '0; gpos_d = '0;
      bsize_d = '0; seen_d = '0; prod_d = '0; error_d = 1'b0; nul_d = 1'b0; bhead_d = 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (item_go) begin
            if (head_i.is_start) begin
              state_d  = S_PATH;
              tcount_d = '0; tptr_d = '0; pend_d = '0; budget_d = '0; hdr_d = '0;
              gpos_d = '0; bsize_d = '0; seen_d = '0; prod_d = '0; error_d = 1'b0;
              nul_d = 1'b0; bhead_d = 1'b0;
            end else begin
              error_d = 1'b1; state_d = S_DRAIN;
            end
          end
        end
        S_PATH, S_TYPES, S_STRING: begin
          if (item_go) begin
            if (tflag && (tcount_q >= TCW'(MAX_TYPES))) begin
              error_d = 1'b1; state_d = S_DRAIN;
            end else if (prod_q >= CW'(MAX_MESSAGE)) begin
              error_d = 1'b1; state_d = S_DRAIN;
            end else begin
              ovalid_d = 1'b1; obyte_d = head_i.data; olast_d = 1'b0;
              obad_d = 1'b0; olen_d = '0;
              prod_d = prod_q + CW'(1);
              if (tflag) begin
                we = 1'b1;
                tcount_d = tcount_q + TCW'(1);
              end
              if ((nul_q || head_i.is_nul) && (seen_q == 2'd3)) begin
                seen_d = '0;
                nul_d  = 1'b0;
                if (state_q == S_PATH) begin
                  state_d = S_TYPES;
                end else begin
                  if (state_q == S_TYPES) begin
                    tptr_d = '0;
                    pend_d = '0;
                  end
                  acc_d = '0; mod_d = '0; state_d = S_WALK_RD;
                end
              end else begin
                seen_d = seen_q + 2'd1;
                nul_d  = nul_q || head_i.is_nul;
              end
            end
          end
        end
        S_GROUP: begin
          if (item_go) begin
            if (gpos_q == 3'd0) begin
              hdr_d = head_i.data;
              if (!bhead_q && ((BW'(hn) + BW'(1) > budget_q) || (PW'(hn) > pend_q))) begin
                error_d = 1'b1; state_d = S_DRAIN;
              end else begin
                if (!bhead_q) begin
                  budget_d = budget_q - BW'(hn) - BW'(1);
                  pend_d   = pend_q - PW'(hn);
                end
                gpos_d = 3'd1;
              end
            end else if (bhead_q && (gpos_q == 3'd4)) begin
              bsize_d = bs_new;
              bhead_d = 1'b0;
              if (bs_new > 32'(MAX_MESSAGE)) begin
                error_d = 1'b1; state_d = S_DRAIN;
              end else begin
                total_d = PW'(total_w);
                hold_d  = v;
                state_d = S_BLOB_Q;
              end
            end else begin
              if (bhead_q) begin
                bsize_d = bs_new;
              end
              fin_go = 1'b1;
            end
          end
        end
        S_BLOB_Q: begin
          quot_d  = 16'(prod_mul >> DIV3_SHIFT);
          state_d = S_BLOB_P;
        end
        S_BLOB_P: begin
          if (slot_free) begin
            if ((packed_v < BW'(gn) + BW'(1)) || (total_q < PW'(gn))) begin
              error_d = 1'b1; state_d = S_DRAIN;
            end else begin
              state_d    = S_GROUP;
              fin_go     = 1'b1;
              fin_v      = hold_q;
              fin_budget = packed_v - BW'(gn) - BW'(1);
              fin_pend   = total_q - PW'(gn);
            end
          end
        end
        S_WALK_RD: begin
          if (tptr_q < tcount_q) begin
            state_d = S_WALK_EV;
          end else if (pend_q != '0) begin
            budget_d = acc_q; gpos_d = '0; state_d = S_GROUP;
          end else begin
            state_d = S_DONE;
          end
        end
        S_WALK_EV: begin
          state_d = S_WALK_RD;
          tptr_d  = tptr_q + TCW'(1);
          case (rdata) inside
            CH_I, CH_F, CH_M: begin
              pend_d = pend_q + PW'(4); acc_d = a1; mod_d = m1;
            end
            CH_H, CH_D, CH_T: begin
              pend_d = pend_q + PW'(8); acc_d = a2; mod_d = m2;
            end
            CH_S, CH_SU, CH_B: begin
              if (pend_q != '0) begin
                tptr_d = tptr_q; budget_d = acc_q; gpos_d = '0; state_d = S_GROUP;
              end else if (rdata == CH_B) begin
                bhead_d = 1'b1; bsize_d = '0; gpos_d = '0; state_d = S_GROUP;
              end else begin
                seen_d = '0; nul_d = 1'b0; state_d = S_STRING;
              end
            end
            default: begin
            end
          endcase
        end
        S_DONE: begin
          if (item_go) begin
            error_d = 1'b1; state_d = S_DRAIN;
          end
        end
        S_DRAIN: begin
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase

      if (fin_go) begin
        budget_d = fin_budget;
        pend_d   = fin_pend;
        if (prod_q >= CW'(MAX_MESSAGE)) begin
          error_d = 1'b1; state_d = S_DRAIN;
        end else begin
          ovalid_d = 1'b1; obyte_d = fin_v; olast_d = 1'b0; obad_d = 1'b0; olen_d = '0;
          prod_d   = prod_q + CW'(1);
          if ({1'b0, gpos_q} + 4'd1 > {1'b0, gn}) begin
            gpos_d = '0;
            if ((fin_budget == '0) != (fin_pend == '0)) begin
              error_d = 1'b1; state_d = S_DRAIN;
            end else if (fin_budget == '0) begin
              acc_d = '0; mod_d = '0; state_d = S_WALK_RD;
            end
          end else begin
            gpos_d = gpos_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tcount_q <= '0;  tptr_q  <= '0;  pend_q  <= '0;  budget_q <= '0;
      acc_q    <= '0;  mod_q   <= '0;  seen_q  <= '0;  hdr_q    <= '0;
      gpos_q   <= '0;  bsize_q <= '0;  nul_q   <= 1'b0; bhead_q <= 1'b0;
      error_q  <= 1'b0; prod_q <= '0;  ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tcount_q <= tcount_d; tptr_q <= tptr_d; pend_q <= pend_d; budget_q <= budget_d;
      acc_q    <= acc_d;    mod_q  <= mod_d;  seen_q <= seen_d; hdr_q    <= hdr_d;
      gpos_q   <= gpos_d;   bsize_q <= bsize_d; nul_q <= nul_d; bhead_q  <= bhead_d;
      error_q  <= error_d;  prod_q <= prod_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    quot_q  <= quot_d;
    hold_q  <= hold_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    obad_q  <= obad_d;
    olen_q  <= olen_d;
  end

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK_EV |-> $past(state_q) == S_WALK_RD)
    else $error("type evaluation without a preceding read");

  a_error_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q |-> state_q == S_DRAIN)
    else $error("error flag set outside the drain state");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tptr_q <= tcount_q) && (tcount_q <= TCW'(MAX_TYPES)))
    else $error("type pointer or count out of range");

endmodule
`default_nettype wire

[hdl/sysex_osc_unpacker_core.sv]
// Top level of the sysex to OSC unpacker: front queue and back-end sequencer.
// A byte result passes through the front queue and then the back-end output register.
// Throughput: one byte per cycle while the output is taken; a finished string then walks
// each type character via S_WALK_RD/S_WALK_EV; blob length packing uses S_BLOB_Q/S_BLOB_P.
// Reset is asynchronous and active low; it empties the queue and returns to awaiting F0.
// The type store is not cleared by reset; it is only read where written in the same message.
`default_nettype none
module sysex_osc_unpacker_core
  import sou_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE = MAX_MESSAGE_DEF,
  parameter int unsigned MAX_TYPES   = MAX_TYPES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte
  input  wire logic       s_axis_tlast,   // in_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_byte, raw_length, zero pad
  output logic            m_axis_tlast,   // end_mark
  output logic            m_axis_tuser    // bad_frame
);

  sou_item_t head;
  logic      head_valid;
  logic      pop;

  sou_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  sou_back #(
    .MAX_MESSAGE (MAX_MESSAGE),
    .MAX_TYPES   (MAX_TYPES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
